@@ hdl/fpn_pkg.sv @@
// ----------------------------------------------------------------------------
// Fractal Perlin noise package
// Shared constants, register indexes, request codes and the sequencer state
// type for the fractal 2D gradient noise block.
// ----------------------------------------------------------------------------
package fpn_pkg;

  // Permutation table geometry.
  localparam int TABLE_SIZE = 256;
  localparam int TABLE_AW   = $clog2(TABLE_SIZE);
  localparam int TABLE_DW   = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_OCTAVES = 16;
  localparam int DEF_FRAC_BITS   = 16;

  // Fixed field widths.
  localparam int COORD_W    = 32;
  localparam int OUT_W      = 24;
  localparam int OCT_CFG_W  = 5;
  localparam int GAIN_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  // Amplitude and gain are unsigned Q1.16 values.
  localparam int                AMP_FRAC = 16;
  localparam logic [GAIN_W-1:0] AMP_ONE  = 17'h10000;

  // Register reset values.
  localparam logic [OCT_CFG_W-1:0] OCT_RESET  = 5'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 17'h08000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 1'b1;

  // Request modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Sequencer states. One pass from ST_SETUP to ST_NEXT handles one octave.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FADE_A,
    ST_HASH_A,
    ST_HASH_B,
    ST_GRAD_00,
    ST_GRAD_10,
    ST_GRAD_01,
    ST_GRAD_11,
    ST_CORNER,
    ST_DIFF,
    ST_LERP_LO,
    ST_LERP_HI,
    ST_LERP_SUM,
    ST_DIFF_V,
    ST_LERP_V,
    ST_NOISE,
    ST_WEIGHT,
    ST_ACCUM,
    ST_NEXT,
    ST_DONE
  } state_e;

endpackage

@@ hdl/fpn_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module fpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/fpn_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiply and round unit
// Registers a signed product each cycle and rounds it to nearest, ties
// upwards, by either the coordinate fraction width or the amplitude width.
// ----------------------------------------------------------------------------
module fpn_mul #(
  parameter int DATA_W    = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic signed [DATA_W-1:0] op_a_i,
  input  logic signed [DATA_W-1:0] op_b_i,
  input  logic                     amp_scale_i,
  output logic signed [DATA_W-1:0] result_o
);
  import fpn_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam logic signed [PROD_W-1:0] HALF_FRAC = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_AMP  = PROD_W'(1) <<< (AMP_FRAC - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic                     amp_scale_q;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;

  // Product register; the scale choice travels with it.
  always_ff @(posedge clk_i) begin
    prod_q      <= op_a_i * op_b_i;
    amp_scale_q <= amp_scale_i;
  end

  // Round half up, then an arithmetic shift for the floor.
  assign biased   = prod_q + (amp_scale_q ? HALF_AMP : HALF_FRAC);
  assign shifted  = amp_scale_q ? (biased >>> AMP_FRAC) : (biased >>> FRAC_BITS);
  assign result_o = shifted[DATA_W-1:0];

endmodule

@@ hdl/fractal_perlin_noise_2d_top.sv @@
// ----------------------------------------------------------------------------
// Fractal 2D Perlin noise
// Sums improved Perlin noise over a configurable number of octaves, using a
// 256-entry permutation table that is loaded through load requests.
// ----------------------------------------------------------------------------
// A load request writes one permutation entry and is taken while the
// sequencer stays idle. An evaluate request occupies the block from
// acceptance until its result moves into the output register, running
// one pass per effective octave. Each octave is a 19-step pass of
// the sequencer: the one shared multiplier issues the eight fade products,
// the three blends, the amplitude weighting and the amplitude update, while
// the single read port of the permutation RAM walks the chain of six
// dependent hash lookups alongside the fade products. The result sits in an
// output register, so a new request is accepted while it waits to be taken.
// The table must be loaded before it is read; its contents after reset are
// undefined.
module fractal_perlin_noise_2d_top #(
  parameter int MAX_OCTAVES = fpn_pkg::DEF_MAX_OCTAVES,
  parameter int FRAC_BITS   = fpn_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [fpn_pkg::TABLE_AW-1:0]        table_index_i,
  input  logic [fpn_pkg::TABLE_DW-1:0]        table_value_i,
  input  logic signed [fpn_pkg::COORD_W-1:0]  coord_u_i,
  input  logic signed [fpn_pkg::COORD_W-1:0]  coord_v_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fpn_pkg::OUT_W-1:0]    noise_value_o,
  input  logic                                cfg_we_i,
  input  logic [fpn_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fpn_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fpn_pkg::*;

  localparam int DATA_W = (FRAC_BITS + 8 > 18) ? FRAC_BITS + 8 : 18;
  localparam int SUM_W  = DATA_W + 6;
  localparam int OCTL_W = $clog2(MAX_OCTAVES + 1);

  typedef logic signed [DATA_W-1:0] dval_t;

  localparam dval_t ONE_Q     = DATA_W'(1) << FRAC_BITS;
  localparam dval_t TEN_Q     = DATA_W'(10) << FRAC_BITS;
  localparam dval_t FIFTEEN_Q = DATA_W'(15) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN_S = ~OUT_MAX_S;

  // Gradient pick for one corner: one of the four diagonals.
  function automatic dval_t corner(input logic [1:0] h, input dval_t x, input dval_t y);
    dval_t xs;
    dval_t ys;
    xs = h[0] ? -x : x;
    ys = h[1] ? -y : y;
    return xs + ys;
  endfunction

  state_e state_q, state_d;

  logic [OCT_CFG_W-1:0] oct_cfg_q;
  logic [GAIN_W-1:0]    gain_cfg_q;
  logic [OCTL_W-1:0]    oct_eff;
  logic [GAIN_W-1:0]    gain_eff;
  logic [OCTL_W-1:0]    oct_left_q;

  logic [COORD_W-1:0]  su_q, sv_q;
  logic [TABLE_AW-1:0] cu_q, cv_q, ha_q, hb_q;
  logic [1:0]          g00_q, g10_q, g01_q, g11_q;
  dval_t fu_q, fv_q, fu1_q, fv1_q, au_q, av_q, eu_q, ev_q;
  dval_t c00_q, c10_q, c01_q, c11_q, dlo_q, dhi_q, lo_q, hi_q, nz_q;
  dval_t fu_w, fv_w;
  logic [GAIN_W-1:0]       amp_q, gain_q;
  logic signed [SUM_W-1:0] sum_q;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_data_q;
  logic signed [OUT_W-1:0] sat_sum;
  logic                    out_free;

  logic                in_accept;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_raddr;
  logic [TABLE_DW-1:0] ram_rdata;

  dval_t mul_a, mul_b, mul_r;
  logic  mul_amp;

  // Effective octave count and gain, clamped to their limits.
  assign oct_eff  = (oct_cfg_q > OCT_CFG_W'(MAX_OCTAVES)) ? OCTL_W'(MAX_OCTAVES)
                                                          : oct_cfg_q[OCTL_W-1:0];
  assign gain_eff = (gain_cfg_q > AMP_ONE) ? AMP_ONE : gain_cfg_q;

  assign in_accept = in_valid_i && in_ready_o;
  assign ram_we    = in_accept && (mode_i == MODE_LOAD);
  assign out_free  = !out_valid_q || out_ready_i;

  // Fraction parts of the scaled coordinates.
  assign fu_w = {{(DATA_W - FRAC_BITS){1'b0}}, su_q[FRAC_BITS-1:0]};
  assign fv_w = {{(DATA_W - FRAC_BITS){1'b0}}, sv_q[FRAC_BITS-1:0]};

  // Saturate the octave sum to the output range.
  assign sat_sum = (sum_q > OUT_MAX_S) ? OUT_MAX_S[OUT_W-1:0] :
                   (sum_q < OUT_MIN_S) ? OUT_MIN_S[OUT_W-1:0] : sum_q[OUT_W-1:0];

  // Permutation table.
  fpn_ram #(
    .WIDTH (TABLE_DW),
    .DEPTH (TABLE_SIZE)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (table_index_i),
    .wdata_i (table_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier.
  fpn_mul #(
    .DATA_W    (DATA_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i       (clk_i),
    .op_a_i      (mul_a),
    .op_b_i      (mul_b),
    .amp_scale_i (mul_amp),
    .result_o    (mul_r)
  );

  // Sequencer: next state, multiplier operands and table read address.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mul_a      = fu_q;
    mul_b      = au_q;
    mul_amp    = 1'b0;
    ram_raddr  = cu_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (mode_i == MODE_EVAL)) begin
          state_d = (oct_eff == '0) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_FADE_A;
      end
      ST_FADE_A: begin
        mul_a     = fu_q;
        mul_b     = au_q;
        ram_raddr = cu_q;
        state_d   = ST_HASH_A;
      end
      ST_HASH_A: begin
        mul_a     = fv_q;
        mul_b     = av_q;
        ram_raddr = cu_q + TABLE_AW'(1);
        state_d   = ST_HASH_B;
      end
      ST_HASH_B: begin
        mul_a     = fu_q;
        mul_b     = eu_q;
        ram_raddr = ha_q;
        state_d   = ST_GRAD_00;
      end
      ST_GRAD_00: begin
        mul_a     = fv_q;
        mul_b     = ev_q;
        ram_raddr = hb_q;
        state_d   = ST_GRAD_10;
      end
      ST_GRAD_10: begin
        mul_a     = fu_q;
        mul_b     = eu_q;
        ram_raddr = ha_q + TABLE_AW'(1);
        state_d   = ST_GRAD_01;
      end
      ST_GRAD_01: begin
        mul_a     = fv_q;
        mul_b     = ev_q;
        ram_raddr = hb_q + TABLE_AW'(1);
        state_d   = ST_GRAD_11;
      end
      ST_GRAD_11: begin
        mul_a   = fu_q;
        mul_b   = eu_q;
        state_d = ST_CORNER;
      end
      ST_CORNER: begin
        mul_a   = fv_q;
        mul_b   = ev_q;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        state_d = ST_LERP_LO;
      end
      ST_LERP_LO: begin
        mul_a   = eu_q;
        mul_b   = dlo_q;
        state_d = ST_LERP_HI;
      end
      ST_LERP_HI: begin
        mul_a   = eu_q;
        mul_b   = dhi_q;
        state_d = ST_LERP_SUM;
      end
      ST_LERP_SUM: begin
        state_d = ST_DIFF_V;
      end
      ST_DIFF_V: begin
        state_d = ST_LERP_V;
      end
      ST_LERP_V: begin
        mul_a   = ev_q;
        mul_b   = dlo_q;
        state_d = ST_NOISE;
      end
      ST_NOISE: begin
        state_d = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        mul_a   = nz_q;
        mul_b   = {{(DATA_W - GAIN_W){1'b0}}, amp_q};
        mul_amp = 1'b1;
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        mul_a   = {{(DATA_W - GAIN_W){1'b0}}, amp_q};
        mul_b   = {{(DATA_W - GAIN_W){1'b0}}, gain_q};
        mul_amp = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        state_d = (oct_left_q == OCTL_W'(1)) ? ST_DONE : ST_SETUP;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cfg_q  <= OCT_RESET;
      gain_cfg_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OCTAVES: oct_cfg_q  <= cfg_data_i[OCT_CFG_W-1:0];
        CFG_GAIN:    gain_cfg_q <= cfg_data_i[GAIN_W-1:0];
      endcase
    end
  end

  // Octave counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_left_q <= '0;
    end else if (in_accept && (mode_i == MODE_EVAL)) begin
      oct_left_q <= oct_eff;
    end else if (state_q == ST_NEXT) begin
      oct_left_q <= oct_left_q - OCTL_W'(1);
    end
  end

  // Output register: holds the result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_data_q <= sat_sum;
    end
  end

  // Octave datapath: most states capture what the previous step produced.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode_i == MODE_EVAL)) begin
          su_q   <= coord_u_i;
          sv_q   <= coord_v_i;
          sum_q  <= '0;
          amp_q  <= AMP_ONE;
          gain_q <= gain_eff;
        end
      end
      ST_SETUP: begin
        cu_q  <= su_q[FRAC_BITS +: TABLE_AW];
        cv_q  <= sv_q[FRAC_BITS +: TABLE_AW];
        fu_q  <= fu_w;
        fv_q  <= fv_w;
        fu1_q <= fu_w - ONE_Q;
        fv1_q <= fv_w - ONE_Q;
        au_q  <= (fu_w <<< 2) + (fu_w <<< 1) - FIFTEEN_Q;
        av_q  <= (fv_w <<< 2) + (fv_w <<< 1) - FIFTEEN_Q;
      end
      ST_HASH_A: begin
        ha_q <= ram_rdata + cv_q;
        eu_q <= mul_r + TEN_Q;
      end
      ST_HASH_B: begin
        hb_q <= ram_rdata + cv_q;
        ev_q <= mul_r + TEN_Q;
      end
      ST_GRAD_00: begin
        g00_q <= ram_rdata[1:0];
        eu_q  <= mul_r;
      end
      ST_GRAD_10: begin
        g10_q <= ram_rdata[1:0];
        ev_q  <= mul_r;
      end
      ST_GRAD_01: begin
        g01_q <= ram_rdata[1:0];
        eu_q  <= mul_r;
      end
      ST_GRAD_11: begin
        g11_q <= ram_rdata[1:0];
        ev_q  <= mul_r;
      end
      ST_CORNER: begin
        c00_q <= corner(g00_q, fu_q, fv_q);
        c10_q <= corner(g10_q, fu1_q, fv_q);
        c01_q <= corner(g01_q, fu_q, fv1_q);
        c11_q <= corner(g11_q, fu1_q, fv1_q);
        eu_q  <= mul_r;
      end
      ST_DIFF: begin
        dlo_q <= c10_q - c00_q;
        dhi_q <= c11_q - c01_q;
        ev_q  <= mul_r;
      end
      ST_LERP_HI: begin
        lo_q <= c00_q + mul_r;
      end
      ST_LERP_SUM: begin
        hi_q <= c01_q + mul_r;
      end
      ST_DIFF_V: begin
        dlo_q <= hi_q - lo_q;
      end
      ST_NOISE: begin
        nz_q <= lo_q + mul_r;
      end
      ST_ACCUM: begin
        sum_q <= sum_q + SUM_W'(mul_r);
      end
      ST_NEXT: begin
        amp_q <= mul_r[GAIN_W-1:0];
        su_q  <= su_q << 1;
        sv_q  <= sv_q << 1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_data_q;

`ifndef SYNTHESIS
  // An octave pass never starts with no octaves left.
  a_octaves_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (oct_left_q != '0))
    else $error("octave pass started with no octaves left");

  // The amplitude never grows beyond one.
  a_amp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (amp_q <= AMP_ONE))
    else $error("amplitude exceeds one");

  // An accepted evaluate request starts an octave pass or goes straight to the result.
  a_eval_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_EVAL))
      |=> ((state_q == ST_SETUP) || (state_q == ST_DONE)))
    else $error("evaluate request did not start");
`endif

endmodule
